// ===== rtl/core/ldlb_pkg.sv =====
`default_nettype none

package ldlb_pkg;

   localparam int LANDMARKS   = 112;
   localparam int NODES       = 4096;
   localparam int LM_W        = 7;
   localparam int NODE_W      = 12;
   localparam int DELAY_W     = 32;
   localparam int CRIT_W      = 17;
   localparam int ADDR_W      = LM_W + NODE_W;
   localparam int TABLE_DEPTH = LANDMARKS * NODES;
   localparam int PROD_W      = DELAY_W + CRIT_W;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CRIT_W-1:0] CRIT_ONE = CRIT_W'(65536);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef struct packed {
      command_type               command;
      logic [LM_W-1:0]           landmark_id;
      logic [NODE_W-1:0]         source_node;
      logic [NODE_W-1:0]         goal_node;
      logic [DELAY_W-1:0]        path_delay;
      logic [CRIT_W-1:0]         crit_weight;
      logic                      is_channel;
   } req_item_type;

   typedef struct packed {
      logic load_we;
      logic capture;
      logic rd_en;
      logic mul_en;
      logic out_load;
   } dp_ctrl_type;

   typedef struct packed {
      logic lm_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ldlb_ctrl.sv =====
`default_nettype none

module ldlb_ctrl
   import ldlb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire req_item_type  item,
   input  wire dp_status_type sts,
   output      dp_ctrl_type   ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_MUL,
      ST_PUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (item.command == CMD_LOAD) begin
                  ctrl.load_we = 1'b1;
               end else begin
                  ctrl.capture = 1'b1;
                  state_in     = item.is_channel ? ST_WALK : ST_PUSH;
               end
            end
         end
         ST_WALK: begin
            ctrl.rd_en = 1'b1;
            if (sts.lm_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> sts.out_free)
      else $error("result loaded into occupied output register");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      ctrl.rd_en && sts.lm_last |=> !ctrl.rd_en && !req_tready)
      else $error("landmark walk ran past the last landmark");

   a_accept_in_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl.load_we || ctrl.capture) |-> req_tready)
      else $error("transaction taken outside idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ldlb_datapath.sv =====
`default_nettype none

module ldlb_datapath
   import ldlb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_item_type          item,
   input  wire dp_ctrl_type           ctrl,
   output      dp_status_type         sts,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [DELAY_W-1:0]    rsp_bound,
   output      logic                  rsp_fallback
);

   logic [DELAY_W-1:0] mem [0:TABLE_DEPTH-1];

   logic [NODE_W-1:0]  node_ff, goal_ff;
   logic [CRIT_W-1:0]  crit_ff;
   logic               fallback_ff;
   logic [LM_W-1:0]    lm_ff;
   logic               rd_valid_ff;
   logic [DELAY_W-1:0] rd_a_ff, rd_b_ff;
   logic [DELAY_W-1:0] best_ff;
   logic [DELAY_W-1:0] prod_ff;
   logic               out_valid_ff;
   logic [DELAY_W-1:0] out_bound_ff;
   logic               out_fallback_ff;

   logic [DELAY_W-1:0] diff;
   logic [PROD_W-1:0]  prod_full;
   logic               lm_ok;

   assign lm_ok = {1'b0, item.landmark_id} < (LM_W+1)'(LANDMARKS);

   always_ff @(posedge clock) begin
      if (ctrl.load_we && lm_ok) begin
         mem[{item.landmark_id, item.source_node}] <= item.path_delay;
      end
      if (ctrl.rd_en) begin
         rd_a_ff <= mem[{lm_ff, node_ff}];
         rd_b_ff <= mem[{lm_ff, goal_ff}];
      end
   end

   assign diff      = (rd_a_ff >= rd_b_ff) ? (rd_a_ff - rd_b_ff) : (rd_b_ff - rd_a_ff);
   assign prod_full = PROD_W'(best_ff) * PROD_W'(crit_ff);

   // hold query operands, saturate criticality at one
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         node_ff     <= item.source_node;
         goal_ff     <= item.goal_node;
         crit_ff     <= (item.crit_weight > CRIT_ONE) ? CRIT_ONE : item.crit_weight;
         fallback_ff <= !item.is_channel;
         best_ff     <= '0;
      end else if (rd_valid_ff && (diff > best_ff)) begin
         best_ff <= diff;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_full[DELAY_W+15:16];
      end
      if (ctrl.out_load) begin
         out_bound_ff    <= fallback_ff ? '0 : prod_ff;
         out_fallback_ff <= fallback_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lm_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctrl.rd_en;
         if (ctrl.capture) begin
            lm_ff <= '0;
         end else if (ctrl.rd_en) begin
            lm_ff <= lm_ff + LM_W'(1);
         end
         if (ctrl.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.lm_last  = (lm_ff == LM_W'(LANDMARKS - 1));
   assign sts.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_bound    = out_bound_ff;
   assign rsp_fallback = out_fallback_ff;

`ifndef SYNTHESIS
   a_fallback_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_fallback_ff |-> out_bound_ff == '0)
      else $error("fallback transaction carries a non-zero bound");

   a_bound_le_best: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load && !fallback_ff |=> out_bound_ff <= $past(best_ff))
      else $error("bound exceeds largest landmark difference");

   a_lm_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(lm_ff) <= LM_W'(LANDMARKS - 1))
      else $error("landmark counter left the table");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/landmark_delay_lower_bound_core.sv =====
`default_nettype none

// Landmark delay lower bound. A load transaction (req_tuser = 0) writes one
// delay of the landmark x node table, unless its landmark_id is 112 or more,
// and gives no response. A query transaction (req_tuser = 1) walks all 112
// landmarks, one per cycle, reading the source and goal entries from the two
// read ports of the table, and returns the largest absolute delay difference
// times the Q1.16 criticality (saturated at 1.0, truncated). A query passes
// through the landmark walk, the read drain, the multiply and the output
// load before the next transaction can be accepted; a query on a
// non-channel node skips the walk, drain and multiply and returns a zero
// bound with rsp_tuser set. One transaction is worked on at a time; a
// finished response waits in the output register while the next
// transaction is accepted, and a query whose response finds that register
// still occupied holds until rsp_tready frees it.
// Entries must be loaded before any query reads them.
module landmark_delay_lower_bound_core
   import ldlb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // landmark_id, source_node, goal_node, path_delay, crit_weight, is_channel
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // delay_bound
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // use_fallback
   output      logic                  rsp_tuser
);

   req_item_type  item;
   dp_ctrl_type   ctrl;
   dp_status_type sts;

   assign item.command        = command_type'(req_tuser);
   assign item.landmark_id    = req_tdata[6:0];
   assign item.source_node    = req_tdata[18:7];
   assign item.goal_node      = req_tdata[30:19];
   assign item.path_delay     = req_tdata[62:31];
   assign item.crit_weight    = req_tdata[79:63];
   assign item.is_channel     = req_tdata[80];

   ldlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .item       (item),
      .sts        (sts),
      .ctrl       (ctrl)
   );

   ldlb_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .ctrl         (ctrl),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_bound    (rsp_tdata),
      .rsp_fallback (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== bench/landmark_delay_lower_bound_core_test.sv =====
`default_nettype none

module landmark_delay_lower_bound_core_test;
   import ldlb_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int HOLD_OFF_LEN   = 600;
   localparam int PHASE_ITEMS    = 170;
   localparam int MAX_POOL_NODES = 6;

   typedef struct packed {
      logic [DELAY_W-1:0] delay_bound;
      logic               use_fallback;
   } bound_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   logic [DELAY_W-1:0] delay_mirror [int];
   bit                 node_loaded [int];
   int                 loaded_nodes [$];
   bound_result_type   pending_bounds [$];
   bound_result_type   oldest_bound;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_off_request   = 1'b0;
   int hold_left          = 0;
   int cycle_count        = 0;
   int error_count        = 0;
   int items_sent         = 0;
   int loads_sent         = 0;
   int bounds_checked     = 0;
   int fallbacks_checked  = 0;

   landmark_delay_lower_bound_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d bounds outstanding", $time,
                  pending_bounds.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_left = HOLD_OFF_LEN;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bounds.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none, actual bound %h fallback %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            oldest_bound = pending_bounds.pop_front();
            if (oldest_bound.use_fallback) fallbacks_checked++;
            else bounds_checked++;
            if (rsp_tdata !== oldest_bound.delay_bound) begin
               error_count++;
               $display("%0t: delay_bound mismatch, expected %h, actual %h", $time,
                        oldest_bound.delay_bound, rsp_tdata);
            end
            if (rsp_tuser !== oldest_bound.use_fallback) begin
               error_count++;
               $display("%0t: use_fallback mismatch, expected %b, actual %b", $time,
                        oldest_bound.use_fallback, rsp_tuser);
            end
         end
      end
   end

   function automatic logic [DELAY_W-1:0] mirrored_delay(int lm, int node);
      int key;
      key = lm * NODES + node;
      if (delay_mirror.exists(key)) return delay_mirror[key];
      return '0;
   endfunction

   function automatic bound_result_type lower_bound_of(req_item_type it);
      bound_result_type   res;
      logic [DELAY_W-1:0] a;
      logic [DELAY_W-1:0] b;
      logic [DELAY_W-1:0] diff;
      logic [DELAY_W-1:0] best;
      logic [CRIT_W-1:0]  crit;
      logic [63:0]        prod;
      res = '0;
      if (!it.is_channel) begin
         res.use_fallback = 1'b1;
         return res;
      end
      best = '0;
      for (int lm = 0; lm < LANDMARKS; lm++) begin
         a = mirrored_delay(lm, int'(it.source_node));
         b = mirrored_delay(lm, int'(it.goal_node));
         diff = (a >= b) ? a - b : b - a;
         if (diff > best) best = diff;
      end
      crit = (it.crit_weight > CRIT_ONE) ? CRIT_ONE : it.crit_weight;
      prod = (64'(best) * 64'(crit)) >> 16;
      res.delay_bound = prod[DELAY_W-1:0];
      return res;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_request(req_item_type it);
      return REQ_DATA_W'({it.is_channel, it.crit_weight, it.path_delay, it.goal_node,
                          it.source_node, it.landmark_id});
   endfunction

   function automatic logic [DELAY_W-1:0] random_delay();
      case ($urandom_range(31))
         0: return '0;
         1: return '1;
         default: return $urandom() >> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [CRIT_W-1:0] random_crit();
      case ($urandom_range(7))
         0: return CRIT_ONE;
         1: return '0;
         2: return CRIT_W'($urandom_range(65537, 131071));
         default: return CRIT_W'($urandom_range(65536));
      endcase
   endfunction

   function automatic req_item_type random_fields();
      req_item_type it;
      it.command        = command_type'($urandom_range(1));
      it.landmark_id    = LM_W'($urandom());
      it.source_node    = NODE_W'($urandom());
      it.goal_node      = NODE_W'($urandom());
      it.path_delay     = $urandom();
      it.crit_weight    = CRIT_W'($urandom());
      it.is_channel     = 1'($urandom());
      return it;
   endfunction

   function automatic req_item_type make_load(int lm, int node, logic [DELAY_W-1:0] delay);
      req_item_type it;
      it = random_fields();
      it.command        = CMD_LOAD;
      it.landmark_id    = LM_W'(lm);
      it.source_node    = NODE_W'(node);
      it.path_delay     = delay;
      return it;
   endfunction

   function automatic req_item_type make_query(int src, int goal, logic [CRIT_W-1:0] crit,
                                               logic chan);
      req_item_type it;
      it = random_fields();
      it.command     = CMD_QUERY;
      it.source_node = NODE_W'(src);
      it.goal_node   = NODE_W'(goal);
      it.crit_weight = crit;
      it.is_channel  = chan;
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_request(it);
      req_tuser  <= it.command;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (it.command == CMD_LOAD) begin
         loads_sent++;
         if (int'(it.landmark_id) < LANDMARKS)
            delay_mirror[int'(it.landmark_id) * NODES + int'(it.source_node)] =
               it.path_delay;
      end else begin
         pending_bounds.insert(pending_bounds.size(), lower_bound_of(it));
      end
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_bounds.size() != 0);
   endtask

   task automatic fill_node(int node);
      for (int lm = 0; lm < LANDMARKS; lm++) send_item(make_load(lm, node, random_delay()));
      node_loaded[node] = 1'b1;
      loaded_nodes.insert(loaded_nodes.size(), node);
   endtask

   task automatic fill_fresh_node();
      int node;
      do node = $urandom_range(1, NODES - 2); while (node_loaded.exists(node));
      fill_node(node);
   endtask

   function automatic int pick_loaded_node();
      return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
   endfunction

   task automatic run_random_phase(int count);
      int stop_at;
      int pick;
      int lm;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 2 && loaded_nodes.size() < MAX_POOL_NODES) begin
            fill_fresh_node();
         end else if (pick < 47) begin
            lm = ($urandom_range(9) == 0) ? $urandom_range(LANDMARKS, 127)
                                          : $urandom_range(LANDMARKS - 1);
            send_item(make_load(lm, pick_loaded_node(), random_delay()));
         end else if (pick < 85) begin
            send_item(make_query(pick_loaded_node(), pick_loaded_node(), random_crit(), 1'b1));
         end else begin
            send_item(make_query($urandom_range(NODES - 1), $urandom_range(NODES - 1),
                                 random_crit(), 1'b0));
         end
      end
   endtask

   task automatic reset_block();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_table_fill();
      fill_node(0);
      fill_node(NODES - 1);
      fill_fresh_node();
      fill_fresh_node();
      drain_responses();
   endtask

   task automatic test_corner_queries();
      send_item(make_query(0, NODES - 1, CRIT_ONE, 1'b1));
      send_item(make_query(NODES - 1, 0, CRIT_ONE, 1'b1));
      send_item(make_query(0, NODES - 1, '0, 1'b1));
      send_item(make_query(0, NODES - 1, '1, 1'b1));
      send_item(make_query(0, NODES - 1, CRIT_W'(1), 1'b1));
      send_item(make_query(NODES - 1, NODES - 1, CRIT_ONE, 1'b1));
      send_item(make_query(0, NODES - 1, CRIT_ONE, 1'b0));
      send_item(make_query(NODES - 1, 0, '1, 1'b0));
      // widest possible difference on landmark zero
      send_item(make_load(0, 0, '1));
      send_item(make_load(0, NODES - 1, '0));
      send_item(make_query(0, NODES - 1, CRIT_ONE, 1'b1));
      send_item(make_query(0, NODES - 1, CRIT_W'(65535), 1'b1));
      send_item(make_query(NODES - 1, 0, CRIT_W'(32768), 1'b1));
      drain_responses();
   endtask

   task automatic test_ignored_loads();
      send_item(make_load(LANDMARKS, 0, 32'h1234_5678));
      send_item(make_load(127, NODES - 1, '1));
      send_item(make_query(0, NODES - 1, CRIT_ONE, 1'b1));
      send_item(make_query(NODES - 1, 0, '1, 1'b1));
      drain_responses();
   endtask

   task automatic test_streaming_no_idle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random_phase(PHASE_ITEMS);
      drain_responses();
   endtask

   task automatic test_sender_gaps();
      sender_idle_pct    = 56;
      receiver_stall_pct = 0;
      run_random_phase(PHASE_ITEMS);
      drain_responses();
   endtask

   task automatic test_receiver_stalls();
      sender_idle_pct    = 0;
      receiver_stall_pct = 56;
      hold_off_request   = 1'b1;
      run_random_phase(PHASE_ITEMS);
      drain_responses();
   endtask

   task automatic test_both_idle();
      sender_idle_pct    = 38;
      receiver_stall_pct = 38;
      run_random_phase(PHASE_ITEMS);
      drain_responses();
   endtask

   initial begin
      reset_block();
      test_table_fill();
      test_corner_queries();
      test_ignored_loads();
      test_streaming_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d transactions: %0d table loads over %0d filled nodes,",
               items_sent, loads_sent, loaded_nodes.size());
      $display("%0d landmark bounds and %0d fallback answers compared, %0d errors",
               bounds_checked, fallbacks_checked, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
